// ===== rtl/bgp_bps_pkg.sv =====
// Shared types and constants for the BGP best-path selector.
package bgp_bps_pkg;

    localparam int POS_W  = 4;
    localparam int PREF_W = 32;
    localparam int LEN_W  = 8;
    localparam int MED_W  = 32;
    localparam int HOP_W  = 32;
    localparam int PEER_W = 8;

    localparam logic CMD_CANDIDATE = 1'b0;
    localparam logic CMD_END       = 1'b1;

    typedef enum logic [0:0] {
        ST_EMPTY,
        ST_OPEN
    } state_t;

    typedef struct packed {
        logic load;
        logic tie;
        logic count;
        logic set_ovf;
        logic report;
        logic found;
    } dp_cmd_t;

    typedef struct packed {
        logic above;
        logic ties;
        logic full;
    } dp_stat_t;

endpackage

// ===== rtl/bgp_bps_ctrl.sv =====
// Sequencing controller: decides per word what the datapath does.
module bgp_bps_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   command,
    input  bgp_bps_pkg::dp_stat_t  stat,
    output bgp_bps_pkg::dp_cmd_t   cmd,
    output logic                   busy,
    output logic                   done
);

    bgp_bps_pkg::state_t state_reg, state_next;
    logic                done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bgp_bps_pkg::ST_EMPTY;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        if (start)
        begin
            unique case (command)
                bgp_bps_pkg::CMD_END:
                begin
                    cmd.report = 1'b1;
                    cmd.found  = (state_reg == bgp_bps_pkg::ST_OPEN);
                    done_next  = 1'b1;
                    state_next = bgp_bps_pkg::ST_EMPTY;
                end
                bgp_bps_pkg::CMD_CANDIDATE:
                begin
                    if (stat.full)
                    begin
                        cmd.set_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.count  = 1'b1;
                        state_next = bgp_bps_pkg::ST_OPEN;
                        priority if (state_reg == bgp_bps_pkg::ST_EMPTY || stat.above)
                            cmd.load = 1'b1;
                        else if (stat.ties)
                            cmd.tie = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // one word per cycle, never stalls
    assign busy = 1'b0;
    assign done = done_reg;

endmodule

// ===== rtl/bgp_bps_datapath.sv =====
// Running-best registers, key comparator, position counter and result registers.
module bgp_bps_datapath #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bgp_bps_pkg::dp_cmd_t               cmd,
    output bgp_bps_pkg::dp_stat_t              stat,
    input  logic                               local_origin,
    input  logic [bgp_bps_pkg::PREF_W-1:0]     local_pref,
    input  logic [bgp_bps_pkg::LEN_W-1:0]      as_path_len,
    input  logic [bgp_bps_pkg::MED_W-1:0]      med,
    input  logic                               from_ebgp,
    input  logic [bgp_bps_pkg::HOP_W-1:0]      next_hop,
    input  logic [bgp_bps_pkg::PEER_W-1:0]     peer_index,
    input  logic                               is_current_best,
    output logic                               found,
    output logic [bgp_bps_pkg::POS_W-1:0]      winner_position,
    output logic                               kept_current,
    output logic                               overflow
);

    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           ovf_reg, ovf_next;
    logic                           cur_in_reg, cur_in_next;
    logic [bgp_bps_pkg::POS_W-1:0]  cur_pos_reg, cur_pos_next;

    logic                               lo_reg;
    logic [bgp_bps_pkg::PREF_W-1:0]     lp_reg;
    logic [bgp_bps_pkg::LEN_W-1:0]      pl_reg;
    logic [bgp_bps_pkg::MED_W-1:0]      md_reg;
    logic                               eb_reg;
    logic [bgp_bps_pkg::HOP_W-1:0]      hop_reg;
    logic [bgp_bps_pkg::PEER_W-1:0]     peer_reg;
    logic [bgp_bps_pkg::POS_W-1:0]      pos_reg;

    logic                               found_reg;
    logic [bgp_bps_pkg::POS_W-1:0]      win_reg;
    logic                               kept_reg;
    logic                               ovf_out_reg;

    logic [CNT_W+bgp_bps_pkg::POS_W-1:0] cnt_ext;
    logic [bgp_bps_pkg::POS_W-1:0]       pos_now;
    logic                                hop_better;
    logic                                rank_above;
    logic                                rank_ties;
    logic                                cnt_full;

    assign cnt_ext = {{bgp_bps_pkg::POS_W{1'b0}}, cnt_reg};
    assign pos_now = cnt_ext[bgp_bps_pkg::POS_W-1:0];

    always_comb
    begin
        priority if (local_origin != lo_reg)
            rank_above = local_origin;
        else if (local_pref != lp_reg)
            rank_above = (local_pref > lp_reg);
        else if (as_path_len != pl_reg)
            rank_above = (as_path_len < pl_reg);
        else if (med != md_reg)
            rank_above = (med < md_reg);
        else if (from_ebgp != eb_reg)
            rank_above = from_ebgp;
        else
            rank_above = 1'b0;
    end

    assign rank_ties = (local_origin == lo_reg) && (local_pref == lp_reg) &&
                       (as_path_len == pl_reg) && (med == md_reg) && (from_ebgp == eb_reg);
    assign cnt_full  = (cnt_reg == CNT_W'(MAX_CANDIDATES));

    assign stat = '{above: rank_above, ties: rank_ties, full: cnt_full};

    assign hop_better = (next_hop < hop_reg) ||
                        ((next_hop == hop_reg) && (peer_index < peer_reg));

    always_comb
    begin
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        cur_in_next  = cur_in_reg;
        cur_pos_next = cur_pos_reg;
        if (cmd.count)
            cnt_next = cnt_reg + CNT_W'(1);
        if (cmd.set_ovf)
            ovf_next = 1'b1;
        if (cmd.load)
        begin
            cur_in_next  = is_current_best;
            cur_pos_next = is_current_best ? pos_now : '0;
        end
        else if (cmd.tie && is_current_best && !cur_in_reg)
        begin
            cur_in_next  = 1'b1;
            cur_pos_next = pos_now;
        end
        if (cmd.report)
        begin
            cnt_next     = '0;
            ovf_next     = 1'b0;
            cur_in_next  = 1'b0;
            cur_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            cur_in_reg  <= 1'b0;
            cur_pos_reg <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            cur_in_reg  <= cur_in_next;
            cur_pos_reg <= cur_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg   <= local_origin;
            lp_reg   <= local_pref;
            pl_reg   <= as_path_len;
            md_reg   <= med;
            eb_reg   <= from_ebgp;
            hop_reg  <= next_hop;
            peer_reg <= peer_index;
            pos_reg  <= pos_now;
        end
        else if (cmd.tie && hop_better)
        begin
            hop_reg  <= next_hop;
            peer_reg <= peer_index;
            pos_reg  <= pos_now;
        end
        if (cmd.report)
        begin
            found_reg   <= cmd.found;
            win_reg     <= !cmd.found ? '0 : (cur_in_reg ? cur_pos_reg : pos_reg);
            kept_reg    <= cmd.found && cur_in_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign found           = found_reg;
    assign winner_position = win_reg;
    assign kept_current    = kept_reg;
    assign overflow        = ovf_out_reg;

endmodule

// ===== rtl/bgp_best_path_select.sv =====
// Top level of the BGP best-path selector.
// Takes one word per clock: busy stays low, so every cycle with start high
// accepts a word. A candidate word is ranked against the running best in the
// cycle it is accepted by a single comparator on the primary keys and the
// (next hop, peer) tie-break. An end word reports the winner in the next
// cycle, with done high for a single cycle; the receiver cannot stall, so
// results must be captured when done is seen. Candidates past MAX_CANDIDATES
// are dropped and flag overflow in the report.
module bgp_best_path_select #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic                               local_origin,
    input  logic [bgp_bps_pkg::PREF_W-1:0]     local_pref,
    input  logic [bgp_bps_pkg::LEN_W-1:0]      as_path_len,
    input  logic [bgp_bps_pkg::MED_W-1:0]      med,
    input  logic                               from_ebgp,
    input  logic [bgp_bps_pkg::HOP_W-1:0]      next_hop,
    input  logic [bgp_bps_pkg::PEER_W-1:0]     peer_index,
    input  logic                               is_current_best,
    output logic                               done,
    output logic                               found,
    output logic [bgp_bps_pkg::POS_W-1:0]      winner_position,
    output logic                               kept_current,
    output logic                               overflow
);

    bgp_bps_pkg::dp_cmd_t  dp_cmd;
    bgp_bps_pkg::dp_stat_t dp_stat;

    bgp_bps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .busy    (busy),
        .done    (done)
    );

    bgp_bps_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .local_origin    (local_origin),
        .local_pref      (local_pref),
        .as_path_len     (as_path_len),
        .med             (med),
        .from_ebgp       (from_ebgp),
        .next_hop        (next_hop),
        .peer_index      (peer_index),
        .is_current_best (is_current_best),
        .found           (found),
        .winner_position (winner_position),
        .kept_current    (kept_current),
        .overflow        (overflow)
    );

endmodule

// ===== rtl/bgp_bps_chk.sv =====
// Port-level checker for the best-path selector, bound to the top level.
module bgp_bps_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               command,
    input logic                               done,
    input logic                               found,
    input logic [bgp_bps_pkg::POS_W-1:0]      winner_position,
    input logic                               kept_current
);

    // end word always yields a report on the next cycle
    a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == bgp_bps_pkg::CMD_END |=> done)
        else $error("end word without report");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && command == bgp_bps_pkg::CMD_END))
        else $error("report without end word");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> winner_position == '0 && !kept_current)
        else $error("empty set reports nonzero fields");

    a_kept_found: assert property (@(posedge clk) disable iff (!rst_n)
        done && kept_current |-> found)
        else $error("kept current without a candidate");

endmodule

bind bgp_best_path_select bgp_bps_chk u_bgp_bps_chk (.*);

// ===== dv/bgp_best_path_select_test.sv =====
// Self-checking testbench for the BGP best-path selector: directed table, then random sets.
`timescale 1ns / 1ps

module bgp_best_path_select_test;

    localparam int MAX_CAND = 16;
    localparam int N_DIR = 20;
    localparam int N_RANDOM = 400;

    typedef struct packed {
        logic                           cmd;
        logic                           lo;
        logic [bgp_bps_pkg::PREF_W-1:0] lp;
        logic [bgp_bps_pkg::LEN_W-1:0]  pl;
        logic [bgp_bps_pkg::MED_W-1:0]  md;
        logic                           eb;
        logic [bgp_bps_pkg::HOP_W-1:0]  hop;
        logic [bgp_bps_pkg::PEER_W-1:0] peer;
        logic                           cur;
    } route_t;

    typedef struct packed {
        logic                          found;
        logic [bgp_bps_pkg::POS_W-1:0] pos;
        logic                          kept;
        logic                          ovf;
    } report_t;

    typedef struct packed {
        route_t  word;
        logic    typed;
        report_t want;
    } dir_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           command;
    logic                           local_origin;
    logic [bgp_bps_pkg::PREF_W-1:0] local_pref;
    logic [bgp_bps_pkg::LEN_W-1:0]  as_path_len;
    logic [bgp_bps_pkg::MED_W-1:0]  med;
    logic                           from_ebgp;
    logic [bgp_bps_pkg::HOP_W-1:0]  next_hop;
    logic [bgp_bps_pkg::PEER_W-1:0] peer_index;
    logic                           is_current_best;
    logic                           done;
    logic                           found;
    logic [bgp_bps_pkg::POS_W-1:0]  winner_position;
    logic                           kept_current;
    logic                           overflow;

    bgp_best_path_select #(
        .MAX_CANDIDATES(MAX_CAND)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .local_origin(local_origin),
        .local_pref(local_pref),
        .as_path_len(as_path_len),
        .med(med),
        .from_ebgp(from_ebgp),
        .next_hop(next_hop),
        .peer_index(peer_index),
        .is_current_best(is_current_best),
        .done(done),
        .found(found),
        .winner_position(winner_position),
        .kept_current(kept_current),
        .overflow(overflow)
    );

    // running best for the open set
    logic                           sel_any;
    logic                           sel_lo;
    logic [bgp_bps_pkg::PREF_W-1:0] sel_lp;
    logic [bgp_bps_pkg::LEN_W-1:0]  sel_pl;
    logic [bgp_bps_pkg::MED_W-1:0]  sel_md;
    logic                           sel_eb;
    logic [bgp_bps_pkg::HOP_W-1:0]  sel_hop;
    logic [bgp_bps_pkg::PEER_W-1:0] sel_peer;
    logic [bgp_bps_pkg::POS_W-1:0]  sel_pos;
    logic                           sel_cur_in;
    logic [bgp_bps_pkg::POS_W-1:0]  sel_cur_pos;
    logic [4:0]                     sel_count;
    logic                           sel_ovf;

    report_t  pending_reports[$];
    dir_row_t dir_table[N_DIR];
    int       errors;
    int       words_sent;
    int       reports_seen;
    int       ovf_reports;
    int       kept_reports;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic clear_selection();
        sel_any = 1'b0;
        sel_lo = 1'b0;
        sel_lp = '0;
        sel_pl = '0;
        sel_md = '0;
        sel_eb = 1'b0;
        sel_hop = '0;
        sel_peer = '0;
        sel_pos = '0;
        sel_cur_in = 1'b0;
        sel_cur_pos = '0;
        sel_count = '0;
        sel_ovf = 1'b0;
    endtask

    function automatic logic beats_best(input route_t r);
        if (r.lo != sel_lo) return r.lo;
        if (r.lp != sel_lp) return r.lp > sel_lp;
        if (r.pl != sel_pl) return r.pl < sel_pl;
        if (r.md != sel_md) return r.md < sel_md;
        if (r.eb != sel_eb) return r.eb;
        return 1'b0;
    endfunction

    task automatic rank_candidate(input route_t r);
        logic [bgp_bps_pkg::POS_W-1:0] pos;
        if (sel_count >= MAX_CAND)
        begin
            sel_ovf = 1'b1;
        end
        else
        begin
            pos = sel_count[bgp_bps_pkg::POS_W-1:0];
            sel_count = sel_count + 5'd1;
            if (!sel_any || beats_best(r))
            begin
                sel_any = 1'b1;
                sel_lo = r.lo;
                sel_lp = r.lp;
                sel_pl = r.pl;
                sel_md = r.md;
                sel_eb = r.eb;
                sel_hop = r.hop;
                sel_peer = r.peer;
                sel_pos = pos;
                sel_cur_in = r.cur;
                sel_cur_pos = r.cur ? pos : '0;
            end
            else if (r.lo == sel_lo && r.lp == sel_lp && r.pl == sel_pl &&
                     r.md == sel_md && r.eb == sel_eb)
            begin
                if (r.cur && !sel_cur_in)
                begin
                    sel_cur_in = 1'b1;
                    sel_cur_pos = pos;
                end
                if (r.hop < sel_hop || (r.hop == sel_hop && r.peer < sel_peer))
                begin
                    sel_hop = r.hop;
                    sel_peer = r.peer;
                    sel_pos = pos;
                end
            end
        end
    endtask

    task automatic close_set(output report_t rep);
        rep.found = sel_any;
        rep.pos = !sel_any ? '0 : (sel_cur_in ? sel_cur_pos : sel_pos);
        rep.kept = sel_any & sel_cur_in;
        rep.ovf = sel_ovf;
        clear_selection();
    endtask

    function automatic dir_row_t mk_row(input logic cmd, input logic lo,
                                        input logic [31:0] lp, input logic [7:0] pl,
                                        input logic [31:0] md, input logic eb,
                                        input logic [31:0] hop, input logic [7:0] peer,
                                        input logic cur, input logic typed,
                                        input logic wf, input logic [3:0] wpos,
                                        input logic wk, input logic wo);
        dir_row_t d;
        d.word = '{cmd, lo, lp, pl, md, eb, hop, peer, cur};
        d.typed = typed;
        d.want = '{wf, wpos, wk, wo};
        return d;
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'($urandom_range(0, 3));
            5: return '0;
            6: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 8'($urandom_range(0, 3));
            5: return '0;
            6: return '1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic route_t random_route(input route_t prev);
        route_t r;
        if (prev.cmd == bgp_bps_pkg::CMD_CANDIDATE && $urandom_range(0, 5) == 0)
        begin
            r = prev;
        end
        else
        begin
            r.lo = 1'($urandom_range(0, 1));
            r.lp = pick32();
            r.pl = pick8();
            r.md = pick32();
            r.eb = 1'($urandom_range(0, 1));
            r.hop = pick32();
            r.peer = pick8();
        end
        r.cmd = bgp_bps_pkg::CMD_CANDIDATE;
        r.cur = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    function automatic int pick_gap(input logic burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic idle(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_word(input route_t w, input logic typed, input report_t want);
        report_t rep;
        @(negedge clk);
        start <= 1'b1;
        command <= w.cmd;
        local_origin <= w.lo;
        local_pref <= w.lp;
        as_path_len <= w.pl;
        med <= w.md;
        from_ebgp <= w.eb;
        next_hop <= w.hop;
        peer_index <= w.peer;
        is_current_best <= w.cur;
        do @(posedge clk); while (busy);
        if (w.cmd == bgp_bps_pkg::CMD_END)
        begin
            close_set(rep);
            if (typed)
                rep = want;
            pending_reports.push_back(rep);
        end
        else
        begin
            rank_candidate(w);
        end
        words_sent++;
    endtask

    always @(posedge clk)
    begin
        report_t want;
        if (done)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch("report strobe with nothing pending");
            end
            else
            begin
                want = pending_reports.pop_front();
                if (found !== want.found)
                    note_mismatch($sformatf("found %b, want %b", found, want.found));
                if (winner_position !== want.pos)
                    note_mismatch($sformatf("winner_position %0d, want %0d",
                                            winner_position, want.pos));
                if (kept_current !== want.kept)
                    note_mismatch($sformatf("kept_current %b, want %b",
                                            kept_current, want.kept));
                if (overflow !== want.ovf)
                    note_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
                reports_seen++;
                if (want.ovf) ovf_reports++;
                if (want.kept) kept_reports++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        route_t  w;
        route_t  prev;
        report_t none;
        logic    burst;
        int      n_cand;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = bgp_bps_pkg::CMD_CANDIDATE;
        local_origin = 1'b0;
        local_pref = '0;
        as_path_len = '0;
        med = '0;
        from_ebgp = 1'b0;
        next_hop = '0;
        peer_index = '0;
        is_current_best = 1'b0;
        errors = 0;
        words_sent = 0;
        reports_seen = 0;
        ovf_reports = 0;
        kept_reports = 0;
        none = '0;
        clear_selection();

        //                   cmd  lo  lp            pl     md            eb  hop
        //                   peer   cur typed found pos kept ovf
        dir_table[0]  = mk_row(bgp_bps_pkg::CMD_END, 0, 0, 0, 0, 0, 0,
                               0, 0, 1, 0, 0, 0, 0);
        dir_table[1]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 32'hFFFF_FFFF, 0, 0, 1,
                               32'hFFFF_FFFF, 8'hFF, 0, 0, 0, 0, 0, 0);
        dir_table[2]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 1, 0, 8'hFF, 32'hFFFF_FFFF, 0,
                               1000, 3, 1, 0, 0, 0, 0, 0);
        dir_table[3]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 1, 0, 8'hFF, 32'hFFFF_FFFF, 0,
                               0, 0, 0, 0, 0, 0, 0, 0);
        dir_table[4]  = mk_row(bgp_bps_pkg::CMD_END, 0, 0, 0, 0, 0, 0,
                               0, 0, 1, 1, 1, 1, 0);
        // installed route dropped by a better class, then flagged ties and a flagged loser
        dir_table[5]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 10, 3, 5, 0, 50,
                               1, 1, 0, 0, 0, 0, 0);
        dir_table[6]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 20, 3, 5, 0, 60,
                               1, 0, 0, 0, 0, 0, 0);
        dir_table[7]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 20, 3, 5, 0, 40,
                               2, 0, 0, 0, 0, 0, 0);
        dir_table[8]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 20, 3, 5, 0, 70,
                               0, 1, 0, 0, 0, 0, 0);
        dir_table[9]  = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 20, 3, 5, 0, 80,
                               0, 1, 0, 0, 0, 0, 0);
        dir_table[10] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 5, 3, 5, 0, 0,
                               0, 1, 0, 0, 0, 0, 0);
        dir_table[11] = mk_row(bgp_bps_pkg::CMD_END, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0, 0, 0, 0);
        // path length, MED, eBGP, then peer tie-break and an exact duplicate
        dir_table[12] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 7, 9, 100, 0, 5,
                               9, 0, 0, 0, 0, 0, 0);
        dir_table[13] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 7, 8, 100, 0, 6,
                               9, 0, 0, 0, 0, 0, 0);
        dir_table[14] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 7, 8, 50, 0, 7,
                               9, 0, 0, 0, 0, 0, 0);
        dir_table[15] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 7, 8, 50, 1, 9,
                               4, 0, 0, 0, 0, 0, 0);
        dir_table[16] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 7, 8, 50, 1, 9,
                               2, 0, 0, 0, 0, 0, 0);
        dir_table[17] = mk_row(bgp_bps_pkg::CMD_CANDIDATE, 0, 7, 8, 50, 1, 9,
                               2, 0, 0, 0, 0, 0, 0);
        dir_table[18] = mk_row(bgp_bps_pkg::CMD_END, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0, 0, 0, 0);
        dir_table[19] = mk_row(bgp_bps_pkg::CMD_END, 0, 0, 0, 0, 0, 0,
                               0, 0, 1, 0, 0, 0, 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            idle(pick_gap(1'b0));
            send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);
        end

        while (words_sent < N_DIR + N_RANDOM)
        begin
            burst = ($urandom_range(0, 2) == 0);
            n_cand = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_CAND - 2, MAX_CAND + 4)
                                                 : $urandom_range(0, 6);
            prev = '0;
            prev.cmd = bgp_bps_pkg::CMD_END;
            for (int k = 0; k < n_cand; k++)
            begin
                w = random_route(prev);
                idle(pick_gap(burst));
                send_word(w, 1'b0, none);
                prev = w;
            end
            w = random_route(prev);
            w.cmd = bgp_bps_pkg::CMD_END;
            idle(pick_gap(burst));
            send_word(w, 1'b0, none);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d words and %0d reports", words_sent, reports_seen);
        $display("%0d reports flagged overflow, %0d kept the installed route",
                 ovf_reports, kept_reports);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
